// File: design/bil_pkg.sv
`default_nettype none

package bil_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned PIX_W      = LANES * CHAN_W;
  localparam int unsigned FRAC_W     = 4;
  localparam int unsigned FRAC_ONE   = 16;
  // one row blend: at most 255 * 16
  localparam int unsigned ROW_W      = CHAN_W + FRAC_W;
  // full 2x2 blend: at most 255 * 256
  localparam int unsigned SUM_W      = ROW_W + FRAC_W;
  localparam int unsigned SCALE_W    = 9;
  localparam logic [SCALE_W-1:0] OPAQUE_SCALE = SCALE_W'(256);

  typedef struct packed {
    logic [PIX_W-1:0]  top_left;
    logic [PIX_W-1:0]  top_right;
    logic [PIX_W-1:0]  bottom_left;
    logic [PIX_W-1:0]  bottom_right;
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_y;
    logic              span_end;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_pixel;
    logic             span_end_out;
  } pix_out_t;

  typedef struct packed {
    logic [LANES-1:0][ROW_W-1:0] top;
    logic [LANES-1:0][ROW_W-1:0] bot;
    logic [FRAC_W-1:0]           frac_y;
    logic                        span_end;
  } row_t;

  typedef struct packed {
    logic [LANES-1:0][CHAN_W-1:0] val;
    logic                         span_end;
  } col_t;

endpackage

`default_nettype wire

// File: design/bil_hstage.sv
`default_nettype none

module bil_hstage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 stall_o,
  input  wire bil_pkg::pix_in_t data_i,
  output logic                 valid_o,
  input  wire logic            stall_i,
  output bil_pkg::row_t        data_o
);

  logic          valid_q;
  bil_pkg::row_t row_q, row_d;
  logic [bil_pkg::FRAC_W:0] wl;

  assign stall_o = valid_q && stall_i;

  always_comb begin
    wl = (bil_pkg::FRAC_W + 1)'(bil_pkg::FRAC_ONE) - {1'b0, data_i.frac_x};
    row_d.frac_y   = data_i.frac_y;
    row_d.span_end = data_i.span_end;
    for (int l = 0; l < bil_pkg::LANES; l++) begin
      row_d.top[l] =
        bil_pkg::ROW_W'(data_i.top_left[l*bil_pkg::CHAN_W +: bil_pkg::CHAN_W])
          * bil_pkg::ROW_W'(wl)
        + bil_pkg::ROW_W'(data_i.top_right[l*bil_pkg::CHAN_W +: bil_pkg::CHAN_W])
          * bil_pkg::ROW_W'(data_i.frac_x);
      row_d.bot[l] =
        bil_pkg::ROW_W'(data_i.bottom_left[l*bil_pkg::CHAN_W +: bil_pkg::CHAN_W])
          * bil_pkg::ROW_W'(wl)
        + bil_pkg::ROW_W'(data_i.bottom_right[l*bil_pkg::CHAN_W +: bil_pkg::CHAN_W])
          * bil_pkg::ROW_W'(data_i.frac_x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      row_q <= row_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = row_q;

endmodule

`default_nettype wire

// File: design/bil_vstage.sv
`default_nettype none

module bil_vstage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire bil_pkg::row_t data_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output bil_pkg::col_t      data_o
);

  logic          valid_q;
  bil_pkg::col_t col_q, col_d;
  logic [bil_pkg::FRAC_W:0] wt;
  logic [bil_pkg::SUM_W-1:0] sum;

  assign stall_o = valid_q && stall_i;

  always_comb begin
    wt = (bil_pkg::FRAC_W + 1)'(bil_pkg::FRAC_ONE) - {1'b0, data_i.frac_y};
    col_d.span_end = data_i.span_end;
    sum = '0;
    for (int l = 0; l < bil_pkg::LANES; l++) begin
      sum = bil_pkg::SUM_W'(data_i.top[l]) * bil_pkg::SUM_W'(wt)
          + bil_pkg::SUM_W'(data_i.bot[l]) * bil_pkg::SUM_W'(data_i.frac_y);
      col_d.val[l] = sum[bil_pkg::SUM_W-1 -: bil_pkg::CHAN_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      col_q <= col_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = col_q;

endmodule

`default_nettype wire

// File: design/bil_astage.sv
`default_nettype none

module bil_astage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [bil_pkg::SCALE_W-1:0] alpha_scale_i,
  input  wire logic                        valid_i,
  output logic                             stall_o,
  input  wire bil_pkg::col_t               data_i,
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output bil_pkg::pix_out_t                data_o
);

  localparam int unsigned PROD_W = 2 * bil_pkg::CHAN_W;

  logic              valid_q;
  bil_pkg::pix_out_t out_q, out_d;
  logic              opaque;
  logic [PROD_W-1:0] prod;

  assign stall_o = valid_q && stall_i;
  // any scale with the top bit set counts as opaque
  assign opaque  = alpha_scale_i >= bil_pkg::OPAQUE_SCALE;

  always_comb begin
    out_d.span_end_out = data_i.span_end;
    prod = '0;
    for (int l = 0; l < bil_pkg::LANES; l++) begin
      prod = PROD_W'(data_i.val[l])
           * PROD_W'(alpha_scale_i[bil_pkg::CHAN_W-1:0]);
      // lane values already fit 8 bits, so saturation never bites
      out_d.filtered_pixel[l*bil_pkg::CHAN_W +: bil_pkg::CHAN_W] =
        opaque ? data_i.val[l] : prod[PROD_W-1 -: bil_pkg::CHAN_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

// File: design/bilinear_rgba8_filter_4bit_top.sv
`default_nettype none

// Channel   | Signals                                      | Direction
// ----------+----------------------------------------------+----------
// pixel in  | in_valid_i, in_stall_o, in_data_i            | in
// pixel out | out_valid_o, out_stall_i, out_data_o         | out
// alpha cfg | alpha_scale_we_i, alpha_scale_wdata_i        | in
//
// One item per clock while out_stall_i does not hold the pipeline; stages: row blend, column blend, alpha scale.
// Each stage register accepts whenever it is empty or its successor moves, so
// bubbles close up under stall and nothing is dropped or repeated.
// Reset empties the pipeline and sets alpha scale to opaque (256).

module bilinear_rgba8_filter_4bit_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire bil_pkg::pix_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output bil_pkg::pix_out_t                out_data_o,
  input  wire logic                        alpha_scale_we_i,
  input  wire logic [bil_pkg::SCALE_W-1:0] alpha_scale_wdata_i
);

  logic [bil_pkg::SCALE_W-1:0] alpha_scale_q;
  logic                        h_valid, h_stall, v_valid, v_stall;
  bil_pkg::row_t               h_data;
  bil_pkg::col_t               v_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_scale_q <= bil_pkg::OPAQUE_SCALE;
    end else if (alpha_scale_we_i) begin
      alpha_scale_q <= alpha_scale_wdata_i;
    end
  end

  bil_hstage u_hstage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (h_valid),
    .stall_i (h_stall),
    .data_o  (h_data)
  );

  bil_vstage u_vstage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (h_valid),
    .stall_o (h_stall),
    .data_i  (h_data),
    .valid_o (v_valid),
    .stall_i (v_stall),
    .data_o  (v_data)
  );

  bil_astage u_astage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .alpha_scale_i (alpha_scale_q),
    .valid_i       (v_valid),
    .stall_o       (v_stall),
    .data_i        (v_data),
    .valid_o       (out_valid_o),
    .stall_i       (out_stall_i),
    .data_o        (out_data_o)
  );

endmodule

`default_nettype wire
